// File: rtl/core/ecmt_pkg.sv
package ecmt_pkg;

    localparam int UNIT_COUNT = 4096;
    localparam int COUNT_BITS = 32;
    localparam int INDEX_BITS = 12;
    localparam int FUNC_BITS  = 2;
    localparam int OUT_BITS   = 32;
    localparam int ADDR_BITS  = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [FUNC_BITS-1:0] FUNC_ERASE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

    typedef enum logic {
        ALU_INC,
        ALU_LE
    } t_alu_op;

    typedef struct packed {
        t_alu_op               op;
        logic [COUNT_BITS-1:0] a;
        logic [COUNT_BITS-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [COUNT_BITS-1:0] sum;
        logic                  le;
    } t_alu_rsp;

endpackage

// File: rtl/core/ecmt_in_if.sv
interface ecmt_in_if;
    logic                            valid;
    logic                            ready;
    logic [ecmt_pkg::FUNC_BITS-1:0]  func;
    logic [ecmt_pkg::INDEX_BITS-1:0] eu_index;
    logic [31:0]                     count_value;

    modport source (output valid, output func, output eu_index, output count_value,
                    input ready);
    modport sink (input valid, input func, input eu_index, input count_value,
                  output ready);
endinterface

// File: rtl/core/ecmt_out_if.sv
interface ecmt_out_if;
    logic                            valid;
    logic                            ready;
    logic [ecmt_pkg::OUT_BITS-1:0]   count_out;
    logic                            min_valid;
    logic [ecmt_pkg::INDEX_BITS-1:0] min_index;
    logic                            max_valid;
    logic [ecmt_pkg::INDEX_BITS-1:0] max_index;

    modport source (output valid, output count_out, output min_valid, output min_index,
                    output max_valid, output max_index, input ready);
    modport sink (input valid, input count_out, input min_valid, input min_index,
                  input max_valid, input max_index, output ready);
endinterface

// File: rtl/core/erase_count_minmax_table.sv
// channel   dir  handshake      payload
// i_in      in   valid/ready    func, eu_index, count_value
// o_out     out  valid/ready    count_out, min_valid, min_index, max_valid, max_index
//
// erase steps through RD_UNIT, RD_MIN, RD_MAX and UPD to DONE, load and read through
// RD_UNIT and RD_MIN, an index beyond the table goes straight to DONE; the table has
// a single read port and the adder is shared; after reset the table is cleared one
// entry a cycle, all UNIT_COUNT (4096) entries, with i_in.ready low
// a result waits in the output register; the next transaction is accepted meanwhile,
// but a finished one holds until the output register is free
module erase_count_minmax_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecmt_in_if.sink    i_in,
    ecmt_out_if.source o_out
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_UNIT,
        ST_RD_MIN,
        ST_RD_MAX,
        ST_UPD,
        ST_DONE
    } t_state;

    t_state                            r_state;
    logic [ecmt_pkg::ADDR_BITS-1:0]    r_clr;
    logic [ecmt_pkg::FUNC_BITS-1:0]    r_func;
    logic [ecmt_pkg::INDEX_BITS-1:0]   r_idx;
    logic [ecmt_pkg::COUNT_BITS-1:0]   r_val;
    logic [ecmt_pkg::COUNT_BITS-1:0]   r_cnt;
    logic                              r_min_le;
    logic                              r_min_valid;
    logic [ecmt_pkg::INDEX_BITS-1:0]   r_min_idx;
    logic                              r_max_valid;
    logic [ecmt_pkg::INDEX_BITS-1:0]   r_max_idx;
    logic                              r_out_valid;
    logic [ecmt_pkg::OUT_BITS-1:0]     r_count_out;
    logic                              r_out_min_valid;
    logic [ecmt_pkg::INDEX_BITS-1:0]   r_out_min_idx;
    logic                              r_out_max_valid;
    logic [ecmt_pkg::INDEX_BITS-1:0]   r_out_max_idx;

    logic                              accept;
    logic                              in_range;
    logic                              ram_we;
    logic [ecmt_pkg::ADDR_BITS-1:0]    ram_waddr;
    logic [ecmt_pkg::COUNT_BITS-1:0]   ram_wdata;
    logic [ecmt_pkg::ADDR_BITS-1:0]    ram_raddr;
    logic [ecmt_pkg::COUNT_BITS-1:0]   ram_rdata;
    logic [ecmt_pkg::COUNT_BITS-1:0]   rec_cnt;
    logic [ecmt_pkg::COUNT_BITS-1:0]   n_cnt;
    ecmt_pkg::t_alu_req                alu_req;
    ecmt_pkg::t_alu_rsp                alu_rsp;

    assign accept   = i_in.valid && i_in.ready;
    assign in_range = 32'(i_in.eu_index) < 32'(ecmt_pkg::UNIT_COUNT);

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.count_out = r_count_out;
    assign o_out.min_valid = r_out_min_valid;
    assign o_out.min_index = r_out_min_idx;
    assign o_out.max_valid = r_out_max_valid;
    assign o_out.max_index = r_out_max_idx;

    // recorded unit that is the addressed one reads its new count
    always_comb begin
        rec_cnt = ram_rdata;
        if (r_state == ST_RD_MAX && r_min_idx == r_idx) begin
            rec_cnt = r_cnt;
        end
        if (r_state == ST_UPD && r_max_idx == r_idx) begin
            rec_cnt = r_cnt;
        end
    end

    always_comb begin
        alu_req.op = ecmt_pkg::ALU_LE;
        alu_req.a  = r_cnt;
        alu_req.b  = rec_cnt;
        case (r_state)
            ST_RD_MIN: begin
                alu_req.op = ecmt_pkg::ALU_INC;
                alu_req.a  = ram_rdata;
                alu_req.b  = ram_rdata;
            end
            ST_RD_MAX: begin
                alu_req.a = r_cnt;
                alu_req.b = rec_cnt;
            end
            ST_UPD: begin
                alu_req.a = rec_cnt;
                alu_req.b = r_cnt;
            end
            default: begin
                alu_req.op = ecmt_pkg::ALU_LE;
            end
        endcase
    end

    always_comb begin
        case (r_func)
            ecmt_pkg::FUNC_ERASE: n_cnt = alu_rsp.sum;
            ecmt_pkg::FUNC_LOAD:  n_cnt = r_val;
            default:              n_cnt = ram_rdata;
        endcase
    end

    always_comb begin
        ram_raddr = ecmt_pkg::ADDR_BITS'(r_idx);
        case (r_state)
            ST_RD_MIN: ram_raddr = ecmt_pkg::ADDR_BITS'(r_min_idx);
            ST_RD_MAX: ram_raddr = ecmt_pkg::ADDR_BITS'(r_max_idx);
            default:   ram_raddr = ecmt_pkg::ADDR_BITS'(r_idx);
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ecmt_pkg::ADDR_BITS'(r_idx);
        ram_wdata = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_RD_MIN: begin
                ram_we    = (r_func == ecmt_pkg::FUNC_LOAD);
                ram_wdata = n_cnt;
            end
            ST_RD_MAX: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ecmt_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ecmt_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr           <= '0;
            r_min_valid     <= 1'b0;
            r_min_idx       <= '0;
            r_max_valid     <= 1'b0;
            r_max_idx       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_out.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ecmt_pkg::ADDR_BITS'(ecmt_pkg::UNIT_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_func  <= i_in.func;
                        r_idx   <= i_in.eu_index;
                        r_val   <= ecmt_pkg::COUNT_BITS'(i_in.count_value);
                        r_cnt   <= '0;
                        r_state <= in_range ? ST_RD_UNIT : ST_DONE;
                    end
                end
                ST_RD_UNIT: begin
                    r_state <= ST_RD_MIN;
                end
                ST_RD_MIN: begin
                    r_cnt   <= n_cnt;
                    r_state <= (r_func == ecmt_pkg::FUNC_ERASE) ? ST_RD_MAX : ST_DONE;
                end
                ST_RD_MAX: begin
                    r_min_le <= alu_rsp.le;
                    r_state  <= ST_UPD;
                end
                ST_UPD: begin
                    if (!r_min_valid) begin
                        if (r_cnt != ecmt_pkg::COUNT_MAX) begin
                            r_min_valid <= 1'b1;
                            r_min_idx   <= r_idx;
                        end
                    end else if (r_min_le) begin
                        r_min_idx <= r_idx;
                    end
                    if (!r_max_valid) begin
                        if (r_cnt != '0) begin
                            r_max_valid <= 1'b1;
                            r_max_idx   <= r_idx;
                        end
                    end else if (alu_rsp.le) begin
                        r_max_idx <= r_idx;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid     <= 1'b1;
                        r_count_out     <= ecmt_pkg::OUT_BITS'(r_cnt);
                        r_out_min_valid <= r_min_valid;
                        r_out_min_idx   <= r_min_idx;
                        r_out_max_valid <= r_max_valid;
                        r_out_max_idx   <= r_max_idx;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_min_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_min_valid |-> r_min_idx == '0)
        else $error("least-worn index set without a record");

    a_max_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_max_valid |-> r_max_idx == '0)
        else $error("most-worn index set without a record");

    a_min_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_valid |=> r_min_valid)
        else $error("least-worn record lost");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("transaction accepted while busy");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result loaded outside of completion");

endmodule

// File: rtl/core/ecmt_ram.sv
module ecmt_ram (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [ecmt_pkg::ADDR_BITS-1:0]   i_waddr,
    input  logic [ecmt_pkg::COUNT_BITS-1:0]  i_wdata,
    input  logic [ecmt_pkg::ADDR_BITS-1:0]   i_raddr,
    output logic [ecmt_pkg::COUNT_BITS-1:0]  o_rdata
);

    logic [ecmt_pkg::COUNT_BITS-1:0] r_mem [ecmt_pkg::UNIT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/ecmt_alu.sv
module ecmt_alu (
    input  ecmt_pkg::t_alu_req i_req,
    output ecmt_pkg::t_alu_rsp o_rsp
);

    logic [ecmt_pkg::COUNT_BITS-1:0] x;
    logic [ecmt_pkg::COUNT_BITS-1:0] y;
    logic                            cin;
    logic [ecmt_pkg::COUNT_BITS:0]   s;

    // increment: a + 1, compare: b + ~a + 1 carries out when a <= b
    always_comb begin
        if (i_req.op == ecmt_pkg::ALU_INC) begin
            x   = i_req.a;
            y   = ecmt_pkg::COUNT_BITS'(1);
            cin = 1'b0;
        end else begin
            x   = i_req.b;
            y   = ~i_req.a;
            cin = 1'b1;
        end
        s = {1'b0, x} + {1'b0, y} + (ecmt_pkg::COUNT_BITS + 1)'(cin);
    end

    assign o_rsp.sum = s[ecmt_pkg::COUNT_BITS-1:0];
    assign o_rsp.le  = s[ecmt_pkg::COUNT_BITS];

endmodule
